>>> sv/unicode_char_fold_to_ascii_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the character fold block
// Shared concurrent-check shorthands. They sample on clk and are held off
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef UNICODE_CHAR_FOLD_TO_ASCII_TOP_MACROS_SVH
`define UNICODE_CHAR_FOLD_TO_ASCII_TOP_MACROS_SVH

// Same-cycle implication
`define UCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucf check failed: same-cycle implication");

// Next-cycle implication
`define UCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucf check failed: next-cycle implication");

`endif

>>> sv/ucf_pkg.sv
// ---------------------------------------------------------------------------
// ucf_pkg
// Widths and fixed code points for the UTF-16 to ASCII character fold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucf_pkg;

  localparam int CHAR_W = 16;

  typedef logic [CHAR_W-1:0] char_t;

  // XML-valid limits
  localparam char_t CODE_BMP_LO_END   = 16'hD7FF;
  localparam char_t CODE_PRIV_HI_BEG  = 16'hF8FF;
  localparam char_t CODE_BMP_HI_END   = 16'hFFFD;
  localparam char_t CODE_CTRL_END     = 16'h001F;
  localparam char_t CODE_TAB          = 16'h0009;
  localparam char_t CODE_LF           = 16'h000A;
  localparam char_t CODE_CR           = 16'h000D;
  localparam char_t CODE_SPACE        = 16'h0020;

  // Low nibble holds the digit in the numeral groups
  localparam char_t NIBBLE_MASK       = 16'h000F;
  localparam char_t ASCII_ZERO        = 16'h0030;
  localparam char_t ASCII_ONE         = 16'h0031;

  // Fullwidth forms
  localparam char_t FW_LO             = 16'hFF01;
  localparam char_t FW_HI             = 16'hFF5E;
  localparam char_t FW_OFFSET         = 16'hFEE0;

  // Enclosed alphanumerics
  localparam char_t CIRC_NUM_LO       = 16'h2460;
  localparam char_t PAREN_NUM_LO      = 16'h2474;
  localparam char_t DOT_NUM_LO        = 16'h2488;
  localparam char_t PAREN_LC_LO       = 16'h249C;
  localparam char_t CIRC_UC_LO        = 16'h24B6;
  localparam char_t CIRC_LC_LO        = 16'h24D0;

  // Symbol blocks
  localparam char_t BOX_LO            = 16'h2500;
  localparam char_t BLOCK_LO          = 16'h2580;
  localparam char_t SHAPE_LO          = 16'h25A0;
  localparam char_t DINGBAT_LO        = 16'h2600;
  localparam char_t DINGBAT_HI        = 16'h267F;

endpackage

>>> sv/ucf_if.sv
// ---------------------------------------------------------------------------
// ucf_in_if / ucf_out_if
// Valid/ready channels for the fold block: raw code units in, folded out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ucf_in_if;
  logic                     valid;
  logic                     ready;
  logic [ucf_pkg::CHAR_W-1:0] char_in;
  logic                     last_in;

  modport source (output valid, output char_in, output last_in, input ready);
  modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

interface ucf_out_if;
  logic                     valid;
  logic                     ready;
  logic [ucf_pkg::CHAR_W-1:0] char_out;
  logic                     last_out;

  modport source (output valid, output char_out, output last_out, input ready);
  modport sink   (input valid, input char_out, input last_out, output ready);
endinterface

>>> sv/ucf_fold.sv
// ---------------------------------------------------------------------------
// ucf_fold
// Combinational fold of one UTF-16 code unit to its ASCII form.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucf_fold (
  input  logic [ucf_pkg::CHAR_W-1:0] char_in,
  output logic [ucf_pkg::CHAR_W-1:0] char_out
);
  import ucf_pkg::*;

  logic       tbl_hit;
  logic [7:0] tbl_char;
  char_t      nib;

  assign nib = char_in & NIBBLE_MASK;

  // Explicit code table; wins over every range below
  always_comb begin
    tbl_hit  = 1'b1;
    tbl_char = 8'h20;
    case (char_in)
      16'h0000, 16'h2000, 16'h2001, 16'h2002, 16'h2003, 16'h2004, 16'h2005,
      16'h2006, 16'h2007, 16'h2008, 16'h2009, 16'h200A, 16'h200B, 16'h200C,
      16'h200D, 16'h202F, 16'h3000:                                 tbl_char = " ";
      16'h00B6, 16'h2028, 16'h2029:                                 tbl_char = 8'h0A;
      16'h00AD, 16'h00B7, 16'h2010, 16'h2011, 16'h2012, 16'h2013, 16'h2014,
      16'h2015, 16'h2027, 16'h2043, 16'h208B, 16'hFE31, 16'hFE32, 16'hFE58,
      16'hFE63:                                                     tbl_char = "-";
      16'h00B0, 16'h2018, 16'h2019, 16'h201A, 16'h201B, 16'h2032, 16'h2035,
      16'h2039, 16'h203A:                                           tbl_char = 8'h27;
      16'h201C, 16'h201D, 16'h201E, 16'h201F, 16'h2033, 16'h2034, 16'h2036,
      16'h2037, 16'h00AB, 16'h00BB, 16'h3003, 16'h301D, 16'h301E,
      16'h301F:                                                     tbl_char = 8'h22;
      16'h00A7, 16'h2020, 16'h2021, 16'h2022, 16'h2023, 16'h203B,
      16'hFE55:                                                     tbl_char = ":";
      16'h2024, 16'h2025, 16'h2026, 16'h3002, 16'hFE30, 16'hFE52:   tbl_char = ".";
      16'h3001, 16'hFE50, 16'hFE51:                                 tbl_char = ",";
      16'hFE54:                                                     tbl_char = ";";
      16'h00A6, 16'h2016:                                           tbl_char = "|";
      16'h2017, 16'h203E, 16'h203F, 16'h2040, 16'hFE33, 16'hFE49, 16'hFE4A,
      16'hFE4D, 16'hFE4E:                                           tbl_char = "_";
      16'h301C, 16'h3030, 16'hFE34, 16'hFE4B, 16'hFE4C, 16'hFE4F:   tbl_char = "~";
      16'h2038, 16'h2041:                                           tbl_char = "^";
      16'h2030, 16'h2031, 16'hFE6A:                                 tbl_char = "%";
      16'hFE6B:                                                     tbl_char = "@";
      16'h00A9:                                                     tbl_char = "c";
      16'h00B5:                                                     tbl_char = "u";
      16'h00AE:                                                     tbl_char = "r";
      16'h207A, 16'h208A, 16'hFE62:                                 tbl_char = "+";
      16'h2044:                                                     tbl_char = "/";
      16'h2042, 16'hFE61:                                           tbl_char = "*";
      16'h208C, 16'hFE66:                                           tbl_char = "=";
      16'hFE68:                                                     tbl_char = 8'h5C;
      16'hFE5F:                                                     tbl_char = "#";
      16'hFE60:                                                     tbl_char = "&";
      16'hFE69:                                                     tbl_char = "$";
      16'h2045, 16'h3010, 16'h3016, 16'h301A, 16'hFE3B, 16'hFF41,
      16'hFF43:                                                     tbl_char = "[";
      16'h2046, 16'h3011, 16'h3017, 16'h301B, 16'hFE3C, 16'hFF42,
      16'hFF44:                                                     tbl_char = "]";
      16'h208D, 16'h3014, 16'h3018, 16'hFE35, 16'hFE39, 16'hFE59,
      16'hFE5D:                                                     tbl_char = "(";
      16'h208E, 16'h3015, 16'h3019, 16'hFE36, 16'hFE3A, 16'hFE5A,
      16'hFE5E:                                                     tbl_char = ")";
      16'h3008, 16'h300A, 16'hFF3D, 16'hFF3F, 16'hFF64:             tbl_char = "<";
      16'h3009, 16'h300B, 16'hFF3E, 16'hFF40, 16'hFF65:             tbl_char = ">";
      16'hFE37, 16'hFE5B:                                           tbl_char = "{";
      16'hFE38, 16'hFE5C:                                           tbl_char = "}";
      16'h00A1, 16'h00AC, 16'h203C, 16'h203D, 16'hFE57:             tbl_char = "!";
      16'h00BF, 16'hFE56:                                           tbl_char = "?";
      16'h00B9:                                                     tbl_char = "1";
      16'h00B2:                                                     tbl_char = "2";
      16'h00B3:                                                     tbl_char = "3";
      16'h3007, 16'h24EA:                                           tbl_char = "0";
      default:                                                      tbl_hit  = 1'b0;
    endcase
  end

  // Numeral groups, ranges, then XML validity
  always_comb begin
    if (tbl_hit) begin
      char_out = {8'h00, tbl_char};
    end else if (char_in == 16'h2070 ||
                 (char_in >= 16'h2074 && char_in <= 16'h2079) ||
                 (char_in >= 16'h2080 && char_in <= 16'h2089) ||
                 (char_in >= 16'h3021 && char_in <= 16'h3029)) begin
      char_out = ASCII_ZERO + nib;
    end else if ((char_in >= 16'h3220 && char_in <= 16'h3228) ||
                 (char_in >= 16'h3280 && char_in <= 16'h3288)) begin
      // ideograph numerals start at one with nibble zero
      char_out = ASCII_ONE + nib;
    end else if (char_in >= FW_LO && char_in <= FW_HI) begin
      char_out = char_in - FW_OFFSET;
    end else if (char_in >= CIRC_NUM_LO && char_in <= CIRC_NUM_LO + 16'd8) begin
      char_out = char_in - CIRC_NUM_LO + ASCII_ONE;
    end else if (char_in >= PAREN_NUM_LO && char_in <= PAREN_NUM_LO + 16'd8) begin
      char_out = char_in - PAREN_NUM_LO + ASCII_ONE;
    end else if (char_in >= DOT_NUM_LO && char_in <= DOT_NUM_LO + 16'd8) begin
      char_out = char_in - DOT_NUM_LO + ASCII_ONE;
    end else if (char_in >= PAREN_LC_LO && char_in < CIRC_UC_LO) begin
      char_out = char_in - PAREN_LC_LO + 16'h0061;
    end else if (char_in >= CIRC_UC_LO && char_in < CIRC_LC_LO) begin
      char_out = char_in - CIRC_UC_LO + 16'h0041;
    end else if (char_in >= CIRC_LC_LO && char_in <= CIRC_LC_LO + 16'd25) begin
      char_out = char_in - CIRC_LC_LO + 16'h0061;
    end else if (char_in >= BOX_LO && char_in < BLOCK_LO) begin
      char_out = 16'h007C;
    end else if (char_in >= BLOCK_LO && char_in < SHAPE_LO) begin
      char_out = 16'h0023;
    end else if (char_in >= SHAPE_LO && char_in < DINGBAT_LO) begin
      char_out = 16'h002A;
    end else if (char_in >= DINGBAT_LO && char_in <= DINGBAT_HI) begin
      char_out = 16'h002E;
    end else if (char_in <= CODE_CTRL_END) begin
      // only tab, LF and CR survive among the controls
      char_out = (char_in == CODE_TAB || char_in == CODE_LF || char_in == CODE_CR) ?
                 char_in : CODE_SPACE;
    end else if (char_in <= CODE_BMP_LO_END) begin
      char_out = char_in;
    end else if (char_in >= CODE_PRIV_HI_BEG && char_in <= CODE_BMP_HI_END) begin
      char_out = char_in;
    end else begin
      char_out = CODE_SPACE;
    end
  end

endmodule

>>> sv/unicode_char_fold_to_ascii_top.sv
// ---------------------------------------------------------------------------
// unicode_char_fold_to_ascii_top
// Folds a UTF-16 code unit stream to ASCII, one item per clock.
//
// One item is taken and one delivered every clock cycle while the output
// side is ready. An accepted item passes through the input register and then
// the result register, with the combinational fold logic between them.
// Either register refills in the same cycle it drains, so stalls on the
// output back up through the two stages without losing or repeating items.
// Reset clears only the valid flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "unicode_char_fold_to_ascii_top_macros.svh"

module unicode_char_fold_to_ascii_top (
  input logic       clk,
  input logic       rst_n,
  ucf_in_if.sink    in_ch,
  ucf_out_if.source out_ch
);
  import ucf_pkg::*;

  logic  in_valid_r,  in_valid_nxt;
  char_t in_char_r;
  logic  in_last_r;
  logic  out_valid_r, out_valid_nxt;
  char_t out_char_r;
  logic  out_last_r;
  logic  res_ready;
  logic  in_load;
  logic  res_load;
  char_t fold_char;

  // Handshake: each stage takes a new item when empty or draining
  assign res_ready   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || res_ready;
  assign in_load     = in_ch.valid && in_ch.ready;
  assign res_load    = in_valid_r && res_ready;

  always_comb begin
    in_valid_nxt  = in_load ? 1'b1 : (res_load ? 1'b0 : in_valid_r);
    out_valid_nxt = res_load ? 1'b1 : ((out_ch.ready) ? 1'b0 : out_valid_r);
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_char_r <= in_ch.char_in;
      in_last_r <= in_ch.last_in;
    end
  end

  ucf_fold u_fold (
    .char_in  (in_char_r),
    .char_out (fold_char)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_char_r <= fold_char;
      out_last_r <= in_last_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.last_out = out_last_r;

  // Checks
  `UCF_ASSERT_NEXT(a_in_lands, in_load, in_valid_r)
  `UCF_ASSERT_NOW(a_empty_ready, !in_valid_r && !out_valid_r, in_ch.ready)
  `UCF_ASSERT_NEXT(a_fold_lands, res_load, out_valid_r && out_char_r == $past(fold_char))
  `UCF_ASSERT_NEXT(a_last_lands, res_load, out_last_r == $past(in_last_r))

endmodule

>>> tb/ucf_fold_checker.sv
// ---------------------------------------------------------------------------
// ucf_fold_checker
// Watches both channels of the character fold block. Every code unit taken
// on the input is folded here and queued; every item that leaves the block
// is compared field by field with the oldest queued fold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucf_fold_checker (
  input  logic clk,
  input  logic rst_n,
  ucf_in_if    in_mon,
  ucf_out_if   out_mon,
  output int   n_fail,
  output int   n_pending
);
  import ucf_pkg::*;

  typedef struct {
    char_t ch;
    logic  last;
  } folded_t;

  folded_t folded_q[$];

  function automatic bit span(char_t c, char_t lo, char_t hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic char_t asc(byte unsigned a);
    return {8'h00, a};
  endfunction

  // Fold of one UTF-16 code unit; fixed codes win over the ranges
  function automatic char_t fold_code_unit(char_t c);
    // spaces and line breaks
    if (c == 16'h0000 || span(c, 16'h2000, 16'h200D) || c == 16'h202F || c == 16'h3000)
      return CODE_SPACE;
    if (c == 16'h00B6 || span(c, 16'h2028, 16'h2029)) return CODE_LF;
    // dashes, quotes
    if (c == 16'h00AD || c == 16'h00B7 || span(c, 16'h2010, 16'h2015) || c == 16'h2027 ||
        c == 16'h2043 || c == 16'h208B || span(c, 16'hFE31, 16'hFE32) || c == 16'hFE58 ||
        c == 16'hFE63)
      return asc("-");
    if (c == 16'h00B0 || span(c, 16'h2018, 16'h201B) || c == 16'h2032 || c == 16'h2035 ||
        span(c, 16'h2039, 16'h203A))
      return asc("'");
    if (span(c, 16'h201C, 16'h201F) || span(c, 16'h2033, 16'h2034) ||
        span(c, 16'h2036, 16'h2037) || c == 16'h00AB || c == 16'h00BB || c == 16'h3003 ||
        span(c, 16'h301D, 16'h301F))
      return asc("\"");
    // punctuation
    if (c == 16'h00A7 || span(c, 16'h2020, 16'h2023) || c == 16'h203B || c == 16'hFE55)
      return asc(":");
    if (span(c, 16'h2024, 16'h2026) || c == 16'h3002 || c == 16'hFE30 || c == 16'hFE52)
      return asc(".");
    if (c == 16'h3001 || span(c, 16'hFE50, 16'hFE51)) return asc(",");
    if (c == 16'hFE54) return asc(";");
    if (c == 16'h00A6 || c == 16'h2016) return asc("|");
    if (c == 16'h2017 || span(c, 16'h203E, 16'h2040) || c == 16'hFE33 ||
        span(c, 16'hFE49, 16'hFE4A) || span(c, 16'hFE4D, 16'hFE4E))
      return asc("_");
    if (c == 16'h301C || c == 16'h3030 || c == 16'hFE34 || span(c, 16'hFE4B, 16'hFE4C) ||
        c == 16'hFE4F)
      return asc("~");
    if (c == 16'h2038 || c == 16'h2041) return asc("^");
    if (span(c, 16'h2030, 16'h2031) || c == 16'hFE6A) return asc("%");
    if (c == 16'hFE6B) return asc("@");
    if (c == 16'h00A9) return asc("c");
    if (c == 16'h00B5) return asc("u");
    if (c == 16'h00AE) return asc("r");
    if (c == 16'h207A || c == 16'h208A || c == 16'hFE62) return asc("+");
    if (c == 16'h2044) return asc("/");
    if (c == 16'h2042 || c == 16'hFE61) return asc("*");
    if (c == 16'h208C || c == 16'hFE66) return asc("=");
    if (c == 16'hFE68) return asc("\\");
    if (c == 16'hFE5F) return asc("#");
    if (c == 16'hFE60) return asc("&");
    if (c == 16'hFE69) return asc("$");
    // brackets, including the fullwidth overrides
    if (c == 16'h2045 || c == 16'h3010 || c == 16'h3016 || c == 16'h301A || c == 16'hFE3B ||
        c == 16'hFF41 || c == 16'hFF43)
      return asc("[");
    if (c == 16'h2046 || c == 16'h3011 || c == 16'h3017 || c == 16'h301B || c == 16'hFE3C ||
        c == 16'hFF42 || c == 16'hFF44)
      return asc("]");
    if (c == 16'h208D || c == 16'h3014 || c == 16'h3018 || c == 16'hFE35 || c == 16'hFE39 ||
        c == 16'hFE59 || c == 16'hFE5D)
      return asc("(");
    if (c == 16'h208E || c == 16'h3015 || c == 16'h3019 || c == 16'hFE36 || c == 16'hFE3A ||
        c == 16'hFE5A || c == 16'hFE5E)
      return asc(")");
    if (c == 16'h3008 || c == 16'h300A || c == 16'hFF3D || c == 16'hFF3F || c == 16'hFF64)
      return asc("<");
    if (c == 16'h3009 || c == 16'h300B || c == 16'hFF3E || c == 16'hFF40 || c == 16'hFF65)
      return asc(">");
    if (c == 16'hFE37 || c == 16'hFE5B) return asc("{");
    if (c == 16'hFE38 || c == 16'hFE5C) return asc("}");
    if (c == 16'h00A1 || c == 16'h00AC || span(c, 16'h203C, 16'h203D) || c == 16'hFE57)
      return asc("!");
    if (c == 16'h00BF || c == 16'hFE56) return asc("?");
    if (c == 16'h00B9) return asc("1");
    if (c == 16'h00B2) return asc("2");
    if (c == 16'h00B3) return asc("3");
    if (c == 16'h3007 || c == 16'h24EA) return asc("0");

    // super/subscript and Hangzhou digits: digit in the low nibble
    if (c == 16'h2070 || span(c, 16'h2074, 16'h2079) || span(c, 16'h2080, 16'h2089) ||
        span(c, 16'h3021, 16'h3029))
      return (c & NIBBLE_MASK) + ASCII_ZERO;
    // parenthesized and circled ideographic numerals start at one
    if (span(c, 16'h3220, 16'h3228) || span(c, 16'h3280, 16'h3288))
      return (c & NIBBLE_MASK) + ASCII_ONE;

    if (span(c, 16'hFF01, 16'hFF5E)) return c - FW_OFFSET;
    if (span(c, 16'h2460, 16'h2468)) return c - 16'h2460 + ASCII_ONE;
    if (span(c, 16'h2474, 16'h247C)) return c - 16'h2474 + ASCII_ONE;
    if (span(c, 16'h2488, 16'h2490)) return c - 16'h2488 + ASCII_ONE;
    if (span(c, 16'h249C, 16'h24B5)) return c - 16'h249C + asc("a");
    if (span(c, 16'h24B6, 16'h24CF)) return c - 16'h24B6 + asc("A");
    if (span(c, 16'h24D0, 16'h24E9)) return c - 16'h24D0 + asc("a");
    if (span(c, 16'h2500, 16'h257F)) return asc("|");
    if (span(c, 16'h2580, 16'h259F)) return asc("#");
    if (span(c, 16'h25A0, 16'h25FF)) return asc("*");
    if (span(c, 16'h2600, 16'h267F)) return asc(".");

    // XML validity
    if (c < 16'h0020)
      return (c == CODE_TAB || c == CODE_LF || c == CODE_CR) ? c : CODE_SPACE;
    if (c <= 16'hD7FF) return c;
    if (span(c, 16'hF8FF, 16'hFFFD)) return c;
    return CODE_SPACE;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("[%0t] mismatch %s: got 0x%04h, expected 0x%04h", $realtime, what, got,
             exp_val);
    n_fail++;
  endtask

  // Queue folds on input items, compare on output items
  always @(posedge clk) begin
    folded_t f;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        f.ch   = fold_code_unit(in_mon.char_in);
        f.last = in_mon.last_in;
        folded_q.push_back(f);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (folded_q.size() == 0) begin
          report_mismatch("unexpected item, char_out", int'(out_mon.char_out), 0);
        end else begin
          f = folded_q.pop_front();
          if (out_mon.char_out !== f.ch)
            report_mismatch("char_out", int'(out_mon.char_out), int'(f.ch));
          if (out_mon.last_out !== f.last)
            report_mismatch("last_out", int'(out_mon.last_out), int'(f.last));
        end
      end
    end
    n_pending = folded_q.size();
  end

endmodule

>>> tb/tb_unicode_char_fold_to_ascii_top.sv
// ---------------------------------------------------------------------------
// tb_unicode_char_fold_to_ascii_top
// Drives code units into the fold block: a directed pass over the corner
// codes, then random code units weighted toward the folded ranges. Both
// sides idle at random, with a calm stretch and two long output stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_unicode_char_fold_to_ascii_top;
  import ucf_pkg::*;

  localparam int N_RANDOM    = 1250;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int N_CORNER    = 25;

  logic clk;
  logic rst_n;
  bit   calm;
  int   n_fail;
  int   n_pending;
  int   quiet_cycles;

  ucf_in_if  in_ch ();
  ucf_out_if out_ch ();

  unicode_char_fold_to_ascii_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ucf_fold_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  // Corner codes: NUL, controls, validity edges, fullwidth edges and the
  // bracket override, digit groups, enclosed forms, symbol blocks
  char_t corner_codes [N_CORNER] = '{
    16'h0000, 16'h0001, 16'h0009, 16'h000D, 16'h001F, 16'h0020, 16'h00B6,
    16'hD7FF, 16'hD800, 16'hF8FE, 16'hF8FF, 16'hFFFD, 16'hFFFE, 16'hFFFF,
    16'hFF01, 16'hFF3D, 16'hFF5E, 16'h2070, 16'h3288, 16'h2468, 16'h24B6,
    16'h24E9, 16'h24EA, 16'h257F, 16'h267F
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random code unit, mostly from the zones where folds happen
  function automatic char_t pick_code_unit();
    case ($urandom_range(0, 6))
      0:       return char_t'($urandom_range(0, 16'hFFFF));
      1:       return char_t'($urandom_range(16'h0000, 16'h00FF));
      2:       return char_t'($urandom_range(16'h2000, 16'h20AF));
      3:       return char_t'($urandom_range(16'h2460, 16'h267F));
      4:       return ($urandom_range(0, 1) != 0) ? char_t'($urandom_range(16'h3000, 16'h303F))
                                                 : char_t'($urandom_range(16'h3220, 16'h328F));
      5:       return char_t'($urandom_range(16'hFE30, 16'hFF6F));
      default: begin
        case ($urandom_range(0, 2))
          0:       return char_t'($urandom_range(16'hD7F0, 16'hD80F));
          1:       return char_t'($urandom_range(16'hF8F0, 16'hF90F));
          default: return char_t'($urandom_range(16'hFFF0, 16'hFFFF));
        endcase
      end
    endcase
  endfunction

  // Offer one item from a falling edge and return at the falling edge after
  // it is taken
  task automatic send_char(char_t c, logic last);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    in_ch.last_in <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.char_in = '0;
    in_ch.last_in = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_CORNER; i++)
      send_char(corner_codes[i], (i % 5) == 4);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 200) && (i < 450);
      send_char(pick_code_unit(), (i == N_RANDOM - 1) || ($urandom_range(0, 7) == 0));
    end
    in_ch.valid <= 1'b0;

    wait (n_pending == 0);
    repeat (8) @(posedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random back-pressure, two long holds to fill the pipe
  initial begin
    int cyc;
    out_ch.ready = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 900 || cyc == 1500) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  // Watchdog: cycles in a row with no item moving on either side
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
+incdir+sv
sv/ucf_pkg.sv
sv/ucf_if.sv
sv/ucf_fold.sv
sv/unicode_char_fold_to_ascii_top.sv
tb/ucf_fold_checker.sv
tb/tb_unicode_char_fold_to_ascii_top.sv
